@@ hdl/deq_pkg.sv @@
// Shared types, constants and ring arithmetic for the double-ended queue.
package deq_pkg;

  localparam int DEPTH    = 32;
  localparam int MAX_OUT  = 32;
  localparam int PTR_W    = $clog2(DEPTH);
  localparam int CNT_W    = $clog2(DEPTH + 1);
  localparam int LIST_MAX = (DEPTH < MAX_OUT) ? DEPTH : MAX_OUT;
  localparam int WORD_W   = 32;
  localparam int ACT_W    = 3;
  localparam int STAT_W   = 2;

  typedef enum logic [ACT_W-1:0] {
    ACT_PUSH_FRONT = 3'd0,
    ACT_PUSH_REAR  = 3'd1,
    ACT_POP_FRONT  = 3'd2,
    ACT_POP_REAR   = 3'd3,
    ACT_LIST       = 3'd4
  } action_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_POP_RD,
    S_LIST_RD,
    S_LIST_OUT
  } state_t;

  typedef struct packed {
    logic    push_front;
    logic    push_rear;
    logic    pop_front;
    logic    pop_rear;
    logic    list_start;
    logic    list_read;
    logic    list_step;
    logic    out_load;
    status_t out_status;
    logic    out_from_mem;
    logic    out_last;
  } cmd_t;

  typedef struct packed {
    logic empty;
    logic full;
    logic list_last;
    logic out_free;
  } stat_t;

  function automatic logic [PTR_W-1:0] ring_add(input logic [PTR_W-1:0] base,
                                                input logic [CNT_W-1:0] offs);
    logic [CNT_W:0] sum;
    sum = {{(CNT_W + 1 - PTR_W){1'b0}}, base} + {1'b0, offs};
    if (sum >= (CNT_W + 1)'(DEPTH)) begin
      sum = sum - (CNT_W + 1)'(DEPTH);
    end
    return sum[PTR_W-1:0];
  endfunction

endpackage

@@ hdl/double_ended_queue_unit.sv @@
// Top level of the bounded double-ended queue of signed 32-bit words.
//
// Input channel s_*: s_tuser carries the action (push front, push rear,
// pop front, pop rear, list), s_tdata the word to push. Output channel m_*:
// m_tuser carries the status (ok, empty, full), m_tdata the popped or listed
// word (zero unless ok), m_tlast marks the final result of an input transfer.
// Every accepted action gives one result, except a list of a nonempty queue,
// which gives one result per stored word front to rear (at most 32); unknown
// actions give none.
// A push needs no storage read, and its result is visible the next cycle.
// A pop first reads the storage into its read register and then loads the
// output register. A list repeats those two steps for each word in turn.
// Input is held off while a pop or list is in progress and while the output
// register holds a result that the receiver has not taken; a stall on
// m_tready simply holds the result.
// Reset empties the queue at once; no clearing pass is needed.
module double_ended_queue_unit (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_tvalid,
  output logic                                s_tready,
  input  logic signed [deq_pkg::WORD_W-1:0]   s_tdata,  // [31:0] value
  input  logic [deq_pkg::ACT_W-1:0]           s_tuser,  // [2:0] action
  output logic                                m_tvalid,
  input  logic                                m_tready,
  output logic signed [deq_pkg::WORD_W-1:0]   m_tdata,  // [31:0] word
  output logic [deq_pkg::STAT_W-1:0]          m_tuser,  // [1:0] status
  output logic                                m_tlast
);
  import deq_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  deq_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .action   (s_tuser),
    .stat     (stat),
    .s_tready (s_tready),
    .cmd      (cmd)
  );

  deq_datapath u_datapath (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .value    (s_tdata),
    .m_tready (m_tready),
    .stat     (stat),
    .m_tvalid (m_tvalid),
    .status   (m_tuser),
    .word     (m_tdata),
    .last     (m_tlast)
  );

endmodule

@@ hdl/deq_ctrl.sv @@
// Controller state machine that sequences pushes, pops and listings.
module deq_ctrl (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         s_tvalid,
  input  logic [deq_pkg::ACT_W-1:0]    action,
  input  deq_pkg::stat_t               stat,
  output logic                         s_tready,
  output deq_pkg::cmd_t                cmd
);
  import deq_pkg::*;

  state_t state;
  state_t state_next;
  logic   accept;

  assign s_tready = (state == S_IDLE) && stat.out_free;
  assign accept   = s_tvalid && s_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          if ((action == ACT_POP_FRONT || action == ACT_POP_REAR) && !stat.empty) begin
            state_next = S_POP_RD;
          end else if (action == ACT_LIST && !stat.empty) begin
            state_next = S_LIST_RD;
          end
        end
      end
      S_POP_RD:   state_next = S_IDLE;
      S_LIST_RD:  state_next = S_LIST_OUT;
      S_LIST_OUT: begin
        if (stat.out_free) begin
          state_next = stat.list_last ? S_IDLE : S_LIST_RD;
        end
      end
      default:    state_next = S_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    cmd.out_status = ST_OK;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          unique case (action)
            ACT_PUSH_FRONT, ACT_PUSH_REAR: begin
              cmd.out_load   = 1'b1;
              cmd.out_last   = 1'b1;
              cmd.out_status = stat.full ? ST_FULL : ST_OK;
              cmd.push_front = !stat.full && (action == ACT_PUSH_FRONT);
              cmd.push_rear  = !stat.full && (action == ACT_PUSH_REAR);
            end
            ACT_POP_FRONT, ACT_POP_REAR: begin
              if (stat.empty) begin
                cmd.out_load   = 1'b1;
                cmd.out_last   = 1'b1;
                cmd.out_status = ST_EMPTY;
              end else begin
                cmd.pop_front = (action == ACT_POP_FRONT);
                cmd.pop_rear  = (action == ACT_POP_REAR);
              end
            end
            ACT_LIST: begin
              if (stat.empty) begin
                cmd.out_load   = 1'b1;
                cmd.out_last   = 1'b1;
                cmd.out_status = ST_EMPTY;
              end else begin
                cmd.list_start = 1'b1;
              end
            end
            default: ;
          endcase
        end
      end
      S_POP_RD: begin
        cmd.out_load     = 1'b1;
        cmd.out_from_mem = 1'b1;
        cmd.out_last     = 1'b1;
      end
      S_LIST_RD: begin
        cmd.list_read = 1'b1;
      end
      S_LIST_OUT: begin
        if (stat.out_free) begin
          cmd.out_load     = 1'b1;
          cmd.out_from_mem = 1'b1;
          cmd.out_last     = stat.list_last;
          cmd.list_step    = 1'b1;
        end
      end
      default: ;
    endcase
  end

endmodule

@@ hdl/deq_datapath.sv @@
// Datapath: ring storage, head and fill registers, list counter and output register.
module deq_datapath (
  input  logic                                clk,
  input  logic                                rst,
  input  deq_pkg::cmd_t                       cmd,
  input  logic signed [deq_pkg::WORD_W-1:0]   value,
  input  logic                                m_tready,
  output deq_pkg::stat_t                      stat,
  output logic                                m_tvalid,
  output logic [deq_pkg::STAT_W-1:0]          status,
  output logic signed [deq_pkg::WORD_W-1:0]   word,
  output logic                                last
);
  import deq_pkg::*;

  logic signed [WORD_W-1:0] mem [DEPTH];
  logic signed [WORD_W-1:0] rdata;
  logic [PTR_W-1:0]         head;
  logic [PTR_W-1:0]         head_dec;
  logic [CNT_W-1:0]         count;
  logic [CNT_W-1:0]         list_k;
  logic [CNT_W-1:0]         list_n;
  logic [PTR_W-1:0]         wr_addr;
  logic [PTR_W-1:0]         rd_addr;
  logic                     wr_en;
  logic                     rd_en;
  logic                     out_valid;

  assign head_dec = (head == '0) ? PTR_W'(DEPTH - 1) : head - PTR_W'(1);
  assign list_n   = (count < CNT_W'(LIST_MAX)) ? count : CNT_W'(LIST_MAX);

  assign wr_en   = cmd.push_front || cmd.push_rear;
  assign wr_addr = cmd.push_front ? head_dec : ring_add(head, count);

  assign rd_en = cmd.pop_front || cmd.pop_rear || cmd.list_read;
  always_comb begin
    if (cmd.pop_front) begin
      rd_addr = head;
    end else if (cmd.pop_rear) begin
      rd_addr = ring_add(head, count - CNT_W'(1));
    end else begin
      rd_addr = ring_add(head, list_k);
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= value;
    end
    if (rd_en) begin
      rdata <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      count <= '0;
    end else begin
      if (cmd.push_front) begin
        head <= head_dec;
      end else if (cmd.pop_front) begin
        head <= ring_add(head, CNT_W'(1));
      end
      if (wr_en) begin
        count <= count + CNT_W'(1);
      end else if (cmd.pop_front || cmd.pop_rear) begin
        count <= count - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.list_start) begin
      list_k <= '0;
    end else if (cmd.list_step) begin
      list_k <= list_k + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      status <= cmd.out_status;
      word   <= cmd.out_from_mem ? rdata : '0;
      last   <= cmd.out_last;
    end
  end

  assign m_tvalid       = out_valid;
  assign stat.empty     = (count == '0);
  assign stat.full      = (count == CNT_W'(DEPTH));
  assign stat.list_last = ((list_k + CNT_W'(1)) == list_n);
  assign stat.out_free  = !out_valid || m_tready;

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(DEPTH))
    else $error("fill count above capacity");

  a_load_free: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> stat.out_free)
    else $error("output register overwritten while held");

  a_push_room: assert property (@(posedge clk) disable iff (rst)
    (cmd.push_front || cmd.push_rear) |-> !stat.full)
    else $error("push into full queue");

  a_pop_data: assert property (@(posedge clk) disable iff (rst)
    (cmd.pop_front || cmd.pop_rear || cmd.list_start) |-> !stat.empty)
    else $error("read from empty queue");

endmodule
